### hw/rtl/tstc_pkg.sv
// Shared types, codes and scaling constants for the touch swipe/tap classifier.
`default_nettype none

package tstc_pkg;

    // Event kinds on the input channel
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_X       = 2'd1;
    localparam logic [1:0] OP_Y       = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef enum logic [2:0] {
        GEST_NONE    = 3'd0,
        GEST_DOWN    = 3'd1,
        GEST_UP      = 3'd2,
        GEST_RIGHT   = 3'd3,
        GEST_LEFT    = 3'd4,
        GEST_CLICK   = 3'd5,
        GEST_TIMEOUT = 3'd6
    } gesture_t;

    // Bit positions in the point flags
    localparam int FLAG_SX = 0;
    localparam int FLAG_SY = 1;
    localparam int FLAG_EX = 2;
    localparam int FLAG_EY = 3;

    localparam int COORD_W   = 12;
    localparam int CFG_W     = 16;
    localparam int ELAPSED_W = 17;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [CFG_W-1:0]     SINCE_MAX   = '1;

    localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd800;
    localparam logic [CFG_W-1:0] CLICK_MAX_RESET = 16'd500;

    // Register indexes on the configuration port
    localparam logic REG_WINDOW    = 1'b0;
    localparam logic REG_CLICK_MAX = 1'b1;

    // X scale 800/1024 reduces to 25/32
    localparam logic [16:0] X_MUL   = 17'd25;
    localparam int          X_SHIFT = 5;
    // Y scale 480/600 is 4/5: divide 4*s by 5 via reciprocal, exact below 81920
    localparam logic [29:0] DIV5_RECIP = 30'h0000CCCD;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic [3:0]         flags;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } pts_t;

    typedef struct packed {
        gesture_t           gesture;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [CFG_W-1:0]   duration_ms;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/tstc_if.sv
// Valid/ready channel interfaces for touch events and gesture results.
`default_nettype none

interface tstc_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [11:0] sample;

    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

interface tstc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  gesture;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [15:0] duration_ms;

    modport source (output valid, gesture, point_x, point_y, duration_ms, input ready);
    modport sink   (input valid, gesture, point_x, point_y, duration_ms, output ready);
endinterface

`default_nettype wire

### hw/rtl/tstc_classify.sv
// Release classification: swipe direction, click or none.
`default_nettype none

module tstc_classify (
    input  tstc_pkg::pts_t      pts,
    input  logic [15:0]         since,
    input  logic [15:0]         click_max_ms,
    output tstc_pkg::res_t      result
);
    import tstc_pkg::*;

    logic               starts;
    logic               ends_all;
    logic               ends_none;
    logic [CFG_W-1:0]   dur;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;

    always_comb
    begin
        starts    = pts.flags[FLAG_SX] & pts.flags[FLAG_SY];
        ends_all  = pts.flags[FLAG_EX] & pts.flags[FLAG_EY];
        ends_none = ~pts.flags[FLAG_EX] & ~pts.flags[FLAG_EY];
        dur       = pts.flags[FLAG_SX] ? since : '0;
        adx       = (pts.ex >= pts.sx) ? pts.ex - pts.sx : pts.sx - pts.ex;
        ady       = (pts.ey >= pts.sy) ? pts.ey - pts.sy : pts.sy - pts.ey;

        result             = '0;
        result.gesture     = GEST_NONE;
        result.duration_ms = dur;
        unique if (starts && ends_all)
        begin
            if (adx <= ady)
                result.gesture = (pts.ey >= pts.sy) ? GEST_DOWN : GEST_UP;
            else
                result.gesture = (pts.ex > pts.sx) ? GEST_RIGHT : GEST_LEFT;
        end
        else if (starts && ends_none && (dur <= click_max_ms))
        begin
            result.gesture = GEST_CLICK;
            result.point_x = pts.sx;
            result.point_y = pts.sy;
        end
        else
            result.gesture = GEST_NONE;
    end

endmodule

`default_nettype wire

### hw/rtl/touch_swipe_tap_classifier.sv
// Top level of the touch swipe/tap classifier with its APB register port.
`default_nettype none

// Channel   Dir   Handshake     Payload
// evt       in    valid/ready   op[1:0], sample[11:0]
// res       out   valid/ready   gesture[2:0], point_x[11:0], point_y[11:0], duration_ms[15:0]
// APB       in    psel/penable  paddr[2:0], pwdata[31:0], prdata[31:0], pready (always high)
//
// One event per clock while the result register can take a result; a result,
// when an event causes one, appears in the result register in the cycle after the transaction.
// The single result register sets the rate: events are held off only while
// it is full and the sink does not take it.
// Reset clears all gesture state, the result valid and loads window 800 ms,
// click limit 500 ms.

module touch_swipe_tap_classifier (
    input  logic        clk,
    input  logic        rst_n,
    tstc_evt_if.sink    evt,
    tstc_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tstc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] window_ms_reg;
    logic [CFG_W-1:0] click_max_reg;
    logic             cfg_wr;

    // Gesture state
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [CFG_W-1:0]     since_reg, since_next;
    pts_t                 pts_reg, pts_next;

    // Result register
    logic res_valid_reg;
    res_t res_reg, res_next;
    logic fire;

    logic evt_acc;
    logic timed_out;

    // Scaling datapath
    logic [16:0]        x_prod;
    logic [COORD_W-1:0] x_scaled;
    logic [29:0]        y_prod;
    logic [COORD_W-1:0] y_scaled;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [CFG_W-1:0]     since_inc;

    res_t cls_res;

    // ------------------------------------------------------------------
    // APB register port: index taken from paddr[2], writes in the access
    // phase, reads return the stored value zero-extended.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg <= WINDOW_RESET;
            click_max_reg <= CLICK_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW:    window_ms_reg <= pwdata[CFG_W-1:0];
                REG_CLICK_MAX: click_max_reg <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW:    prdata = {16'b0, window_ms_reg};
            REG_CLICK_MAX: prdata = {16'b0, click_max_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: take an event whenever the result register is free or
    // being drained in the same cycle.
    // ------------------------------------------------------------------
    assign evt.ready = ~res_valid_reg | res.ready;
    assign evt_acc   = evt.valid & evt.ready;

    // X: s*25/32. Y: (4*s)/5 by reciprocal multiply.
    assign x_prod   = 17'(evt.sample) * X_MUL;
    assign x_scaled = COORD_W'(x_prod >> X_SHIFT);
    assign y_prod   = 30'({evt.sample, 2'b00}) * DIV5_RECIP;
    assign y_scaled = COORD_W'(y_prod >> DIV5_SHIFT);

    // Saturating counters
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign since_inc   = (pts_reg.flags[FLAG_SX] && since_reg != SINCE_MAX)
                         ? since_reg + 1'b1 : since_reg;

    // A shortened window can leave the counter already past the limit
    assign timed_out = elapsed_reg > {1'b0, window_ms_reg};

    tstc_classify u_classify (
        .pts          (pts_reg),
        .since        (since_reg),
        .click_max_ms (click_max_reg),
        .result       (cls_res)
    );

    // ------------------------------------------------------------------
    // Per-event state update and result selection
    // ------------------------------------------------------------------
    always_comb
    begin
        elapsed_next     = elapsed_reg;
        since_next       = since_reg;
        pts_next         = pts_reg;
        fire             = 1'b0;
        res_next         = '0;
        res_next.gesture = GEST_TIMEOUT;

        if (evt_acc)
        begin
            if (timed_out)
            begin
                // Window already exhausted: drop the event, report timeout
                fire         = 1'b1;
                elapsed_next = '0;
                since_next   = '0;
                pts_next     = '0;
            end
            else
            begin
                unique case (evt.op)
                    OP_TICK:
                    begin
                        if (elapsed_inc > {1'b0, window_ms_reg})
                        begin
                            fire         = 1'b1;
                            elapsed_next = '0;
                            since_next   = '0;
                            pts_next     = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                            since_next   = since_inc;
                        end
                    end
                    OP_X:
                    begin
                        if (evt.sample != '0)
                        begin
                            if (!pts_reg.flags[FLAG_SX])
                            begin
                                pts_next.sx             = x_scaled;
                                pts_next.flags[FLAG_SX] = 1'b1;
                                since_next              = '0;
                            end
                            else
                            begin
                                pts_next.ex             = x_scaled;
                                pts_next.flags[FLAG_EX] = 1'b1;
                            end
                        end
                    end
                    OP_Y:
                    begin
                        if (evt.sample != '0)
                        begin
                            if (!pts_reg.flags[FLAG_SY])
                            begin
                                pts_next.sy             = y_scaled;
                                pts_next.flags[FLAG_SY] = 1'b1;
                            end
                            else
                            begin
                                pts_next.ey             = y_scaled;
                                pts_next.flags[FLAG_EY] = 1'b1;
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        fire         = 1'b1;
                        res_next     = cls_res;
                        elapsed_next = '0;
                        since_next   = '0;
                        pts_next     = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            since_reg   <= '0;
            pts_reg     <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            since_reg   <= since_next;
            pts_reg     <= pts_next;
        end
    end

    // Result register: load on a firing event, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.gesture     = res_reg.gesture;
    assign res.point_x     = res_reg.point_x;
    assign res.point_y     = res_reg.point_y;
    assign res.duration_ms = res_reg.duration_ms;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A release always yields a result in the next cycle
    a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_acc && evt.op == OP_RELEASE) |=> res_valid_reg)
        else $error("release transaction gave no result");

    // An end coordinate never exists without its start coordinate
    a_end_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        !((pts_reg.flags[FLAG_EX] && !pts_reg.flags[FLAG_SX]) ||
          (pts_reg.flags[FLAG_EY] && !pts_reg.flags[FLAG_SY])))
        else $error("end point flag set without start point");

    // The press timer only runs once a start X is held
    a_since_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (since_reg != '0) |-> pts_reg.flags[FLAG_SX])
        else $error("press timer running without start X");

    // No event is taken while a pending result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |-> !evt.ready)
        else $error("event accepted while result register stalled");

endmodule

`default_nettype wire
